// File: src/ramp_table_step_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ramp table step scheduler.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef RAMP_TABLE_STEP_SCHEDULER_ASSERT_SVH
`define RAMP_TABLE_STEP_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// Types, codes and the interval selection function shared by the ramp
// table step scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtss_pkg;

   // Default depth of the ramp table.
   localparam int RAMP_DEPTH_DEFAULT = 1024;

   // Field widths.
   localparam int STEPS_W  = 24;
   localparam int ACCEL_W  = 11;
   localparam int CRUISE_W = 20;
   localparam int TIME_W   = 32;
   localparam int POS_W    = 32;
   localparam int RIDX_W   = 10;
   localparam int RVAL_W   = 16;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;

   // Input item actions.
   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_START   = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_SET_POS = 2'd3
   } act_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_TOTAL  = 2'd0,
      REG_ACCEL_STEPS = 2'd1,
      REG_CRUISE      = 2'd2,
      REG_DIRECTION   = 2'd3
   } reg_type;

   // Source of the next step interval.
   typedef enum logic [1:0] {
      SEL_ACCEL  = 2'd0,
      SEL_DECEL  = 2'd1,
      SEL_LAST   = 2'd2,
      SEL_CRUISE = 2'd3
   } sel_type;

   typedef struct packed {
      sel_type            sel;
      logic [STEPS_W-1:0] idx;
   } pick_type;

   // Picks the interval source and table index for the step that follows
   // st steps already taken.
   function automatic pick_type ramp_pick(input logic [STEPS_W-1:0]  st,
                                          input logic [STEPS_W-1:0]  total,
                                          input logic [ACCEL_W-1:0]  accel,
                                          input logic [CRUISE_W-1:0] cruise);
      pick_type           p;
      logic [STEPS_W-1:0] accel_ext;
      accel_ext = {{(STEPS_W-ACCEL_W){1'b0}}, accel};
      p.sel = SEL_CRUISE;
      p.idx = '0;
      if (st < accel_ext) begin
         p.sel = SEL_ACCEL;
         p.idx = st;
      end else if ((total >= accel_ext) && (st >= total - accel_ext)) begin
         p.sel = SEL_DECEL;
         p.idx = total - st - {{(STEPS_W-1){1'b0}}, 1'b1};
      end else if (cruise == '0) begin
         p.sel = SEL_LAST;
         p.idx = {{(STEPS_W-ACCEL_W){1'b0}}, accel - {{(ACCEL_W-1){1'b0}}, 1'b1}};
      end
      return p;
   endfunction

endpackage

// File: src/ramp_table_step_scheduler.sv
// ----------------------------------------------------------------------------
// ramp_table_step_scheduler
// Step pulse scheduler for a trapezoidal move, driven by load, start, tick
// and set position requests and a ramp table of step intervals.
// ----------------------------------------------------------------------------
//  Channel | Ports                     | Transfer
//  --------+---------------------------+-----------------------------------
//  req     | req_valid / req_ready     | one action per transfer
//  rsp     | rsp_valid / rsp_ready     | one result per request
//  csr     | csr_we, csr_index, wdata  | one register write per enabled cycle
//
//  A request is taken into an input register, processed when the result
//  register is free and held in it: one request per cycle sustained while
//  rsp is not stalled. The ramp table read for the next tick is issued
//  ahead from the updated step count, so a tick never waits on memory.
//  A stalled rsp holds the result; one more request still fits in the input
//  register. Synchronous reset clears control, state and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramp_table_step_scheduler #(
   parameter int RAMP_DEPTH = rtss_pkg::RAMP_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [rtss_pkg::TIME_W-1:0]         req_time_now,
   input  logic [rtss_pkg::RIDX_W-1:0]         req_ramp_index,
   input  logic [rtss_pkg::RVAL_W-1:0]         req_ramp_value,
   input  logic signed [rtss_pkg::POS_W-1:0]   req_position_value,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_step_pulse,
   output logic                                rsp_move_done,
   output logic signed [rtss_pkg::POS_W-1:0]   rsp_position,
   output logic                                rsp_index_fault,
   // Configuration write port
   input  logic                                csr_we,
   input  logic [rtss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtss_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int ADDR_W = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;

   // Configuration registers.
   logic [rtss_pkg::STEPS_W-1:0]  step_total_ff, step_total_in;
   logic [rtss_pkg::ACCEL_W-1:0]  accel_steps_ff, accel_steps_in;
   logic [rtss_pkg::CRUISE_W-1:0] cruise_ff, cruise_in;
   logic                          direction_ff, direction_in;

   // Move state.
   logic [rtss_pkg::STEPS_W-1:0]      steps_taken_ff, steps_taken_in;
   logic [rtss_pkg::TIME_W-1:0]       next_time_ff, next_time_in;
   logic signed [rtss_pkg::POS_W-1:0] position_ff, position_in;

   // Input register.
   logic                              in_valid_ff, in_valid_in;
   rtss_pkg::act_type                 in_action_ff;
   logic [rtss_pkg::TIME_W-1:0]       in_time_ff;
   logic [rtss_pkg::RIDX_W-1:0]       in_index_ff;
   logic [rtss_pkg::RVAL_W-1:0]       in_value_ff;
   logic signed [rtss_pkg::POS_W-1:0] in_pos_ff;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_pulse_ff, rsp_pulse_in;
   logic                              rsp_done_ff, rsp_done_in;
   logic signed [rtss_pkg::POS_W-1:0] rsp_pos_ff;
   logic                              rsp_fault_ff, rsp_fault_in;

   // Ramp table, its prefetched read and a copy of entry zero for start.
   logic [rtss_pkg::RVAL_W-1:0] ramp_mem [RAMP_DEPTH];
   logic [rtss_pkg::RVAL_W-1:0] rd_data_ff;
   logic [rtss_pkg::RVAL_W-1:0] entry0_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic [ADDR_W-1:0]           wr_addr;
   logic                        wr_en;

   logic                        fire;
   logic                        req_xfer;
   rtss_pkg::pick_type          cur_pick;
   rtss_pkg::pick_type          pf_pick;
   logic [rtss_pkg::STEPS_W-1:0] accel_ext;
   logic                        tick_fault;
   logic                        start_fault;
   logic [rtss_pkg::TIME_W-1:0] tick_add;
   logic [rtss_pkg::TIME_W-1:0] start_add;
   logic                        tick_step;
   logic signed [rtss_pkg::POS_W-1:0] pos_stepped;

   // Handshake: the result register frees the input register.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration write decode.
   always_comb begin
      step_total_in  = step_total_ff;
      accel_steps_in = accel_steps_ff;
      cruise_in      = cruise_ff;
      direction_in   = direction_ff;
      if (csr_we) begin
         unique case (csr_index)
            rtss_pkg::REG_STEP_TOTAL:  step_total_in  = csr_wdata[rtss_pkg::STEPS_W-1:0];
            rtss_pkg::REG_ACCEL_STEPS: accel_steps_in = csr_wdata[rtss_pkg::ACCEL_W-1:0];
            rtss_pkg::REG_CRUISE:      cruise_in      = csr_wdata[rtss_pkg::CRUISE_W-1:0];
            rtss_pkg::REG_DIRECTION:   direction_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Interval for the step that a tick would issue now.
   assign accel_ext = {{(rtss_pkg::STEPS_W-rtss_pkg::ACCEL_W){1'b0}}, accel_steps_ff};
   assign cur_pick  = rtss_pkg::ramp_pick(steps_taken_ff, step_total_ff,
                                          accel_steps_ff, cruise_ff);
   assign tick_fault = (cur_pick.sel != rtss_pkg::SEL_CRUISE) &&
                       ((cur_pick.idx >= accel_ext) ||
                        ({8'd0, cur_pick.idx} >= 32'(RAMP_DEPTH)));

   always_comb begin
      if (cur_pick.sel == rtss_pkg::SEL_CRUISE) begin
         tick_add = {{(rtss_pkg::TIME_W-rtss_pkg::CRUISE_W){1'b0}}, cruise_ff};
      end else if (tick_fault) begin
         tick_add = '0;
      end else begin
         tick_add = {{(rtss_pkg::TIME_W-rtss_pkg::RVAL_W){1'b0}}, rd_data_ff};
      end
   end

   // Start reads entry zero, which is out of range when no ramp is set.
   assign start_fault = (accel_steps_ff == '0);
   assign start_add   = start_fault ? '0
                        : {{(rtss_pkg::TIME_W-rtss_pkg::RVAL_W){1'b0}}, entry0_ff};

   assign tick_step   = (steps_taken_ff < step_total_ff) && (in_time_ff > next_time_ff);
   assign pos_stepped = direction_ff ? position_ff + 32'sd1 : position_ff - 32'sd1;

   // Action processing for the request in the input register.
   always_comb begin
      steps_taken_in = steps_taken_ff;
      next_time_in   = next_time_ff;
      position_in    = position_ff;
      rsp_pulse_in   = 1'b0;
      rsp_fault_in   = 1'b0;
      wr_en          = 1'b0;
      if (fire) begin
         unique case (in_action_ff)
            rtss_pkg::ACT_LOAD: begin
               wr_en = ({22'd0, in_index_ff} < 32'(RAMP_DEPTH));
            end
            rtss_pkg::ACT_START: begin
               steps_taken_in = {{(rtss_pkg::STEPS_W-1){1'b0}}, 1'b1};
               next_time_in   = in_time_ff + start_add;
               position_in    = pos_stepped;
               rsp_pulse_in   = 1'b1;
               rsp_fault_in   = start_fault;
            end
            rtss_pkg::ACT_TICK: begin
               if (tick_step) begin
                  steps_taken_in = steps_taken_ff + {{(rtss_pkg::STEPS_W-1){1'b0}}, 1'b1};
                  next_time_in   = next_time_ff + tick_add;
                  position_in    = pos_stepped;
                  rsp_pulse_in   = 1'b1;
                  rsp_fault_in   = tick_fault;
               end
            end
            rtss_pkg::ACT_SET_POS: begin
               position_in = in_pos_ff;
            end
            default: ;
         endcase
      end
      rsp_done_in = (steps_taken_in >= step_total_ff);
   end

   // Prefetch address for the next tick, from the state after this cycle.
   assign pf_pick = rtss_pkg::ramp_pick(steps_taken_in, step_total_in,
                                        accel_steps_in, cruise_in);
   assign rd_addr = ({8'd0, pf_pick.idx} < 32'(RAMP_DEPTH)) ? ADDR_W'(pf_pick.idx) : '0;
   assign wr_addr = ADDR_W'(in_index_ff);

   // Ramp table memory with write-through on a same-cycle load.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ramp_mem[wr_addr] <= in_value_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= in_value_ff;
      end else begin
         rd_data_ff <= ramp_mem[rd_addr];
      end
      if (wr_en && (in_index_ff == '0)) begin
         entry0_ff <= in_value_ff;
      end
   end

   // Control, state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         step_total_ff  <= '0;
         accel_steps_ff <= '0;
         cruise_ff      <= '0;
         direction_ff   <= 1'b0;
         steps_taken_ff <= '0;
         next_time_ff   <= '0;
         position_ff    <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_total_ff  <= step_total_in;
         accel_steps_ff <= accel_steps_in;
         cruise_ff      <= cruise_in;
         direction_ff   <= direction_in;
         steps_taken_ff <= steps_taken_in;
         next_time_ff   <= next_time_in;
         position_ff    <= position_in;
      end
   end

   // Payload registers for the input and result stages.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_action_ff <= rtss_pkg::act_type'(req_action);
         in_time_ff   <= req_time_now;
         in_index_ff  <= req_ramp_index;
         in_value_ff  <= req_ramp_value;
         in_pos_ff    <= req_position_value;
      end
      if (fire) begin
         rsp_pulse_ff <= rsp_pulse_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_pos_ff   <= position_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_pulse  = rsp_pulse_ff;
   assign rsp_move_done   = rsp_done_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_index_fault = rsp_fault_ff;

   // Checks on the scheduler's own state handling.
`include "ramp_table_step_scheduler_assert.svh"

   `RTSS_ASSERT_NEXT(a_tick_counts_step, clock, reset,
      fire && (in_action_ff == rtss_pkg::ACT_TICK) && tick_step,
      steps_taken_ff == $past(steps_taken_ff) + 24'd1 && rsp_step_pulse,
      "tick step did not advance the step count")
   `RTSS_ASSERT_NEXT(a_load_keeps_state, clock, reset,
      fire && (in_action_ff == rtss_pkg::ACT_LOAD),
      $stable(steps_taken_ff) && $stable(next_time_ff) && $stable(position_ff),
      "table load changed the move state")
   `RTSS_ASSERT_NEXT(a_input_held, clock, reset,
      in_valid_ff && !fire,
      in_valid_ff && $stable(in_time_ff) && $stable(in_pos_ff),
      "waiting request was lost or overwritten")
   `RTSS_ASSERT_NOW(a_fault_needs_step, clock, reset,
      rsp_valid_ff && rsp_index_fault,
      rsp_step_pulse,
      "index fault reported without a step")

endmodule

// File: dv/ramp_table_step_scheduler_tb.sv
// ----------------------------------------------------------------------------
// ramp_table_step_scheduler_tb
// Self-checking bench for the ramp table step scheduler. A built-in
// scheduler model predicts every result from the accepted requests. Short
// directed moves cover acceleration, plateau, deceleration, missing ramp
// entries and time and position wrap. Random moves with random register
// settings and random idling on both channels follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ramp_table_step_scheduler_tb;

   localparam int RAMP_DEPTH  = rtss_pkg::RAMP_DEPTH_DEFAULT;
   // Leading ramp entries loaded up front. No move in this bench takes more
   // than about sixty steps, so no tick reads an entry past this count.
   localparam int RAMP_FILL   = 64;
   // Far above the slowest legal gap between transfers.
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic        pulse;
      logic        done;
      logic [31:0] pos;
      logic        fault;
   } step_result_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [1:0]                          req_action;
   logic [rtss_pkg::TIME_W-1:0]         req_time_now;
   logic [rtss_pkg::RIDX_W-1:0]         req_ramp_index;
   logic [rtss_pkg::RVAL_W-1:0]         req_ramp_value;
   logic signed [rtss_pkg::POS_W-1:0]   req_position_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic                                rsp_step_pulse;
   logic                                rsp_move_done;
   logic signed [rtss_pkg::POS_W-1:0]   rsp_position;
   logic                                rsp_index_fault;
   logic                                csr_we;
   logic [rtss_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [rtss_pkg::CSR_W-1:0]          csr_wdata;

   // Model copy of the registers and the scheduler state.
   logic [rtss_pkg::STEPS_W-1:0]  cfg_total  = '0;
   logic [rtss_pkg::ACCEL_W-1:0]  cfg_accel  = '0;
   logic [rtss_pkg::CRUISE_W-1:0] cfg_cruise = '0;
   logic                          cfg_dir    = 1'b0;
   logic [rtss_pkg::STEPS_W-1:0]  sched_taken = '0;
   logic [31:0]                   sched_next  = '0;
   logic signed [31:0]            sched_pos   = '0;
   logic [15:0]                   ramp_mem [RAMP_DEPTH];

   step_result_type outcome_q[$];

   bit idle_en = 1'b1;
   int n_errors   = 0;
   int n_requests = 0;
   int n_pulses   = 0;
   int n_faults   = 0;
   int n_finished = 0;
   int n_settings = 0;
   int n_random   = 0;
   int quiet_cycles = 0;

   ramp_table_step_scheduler DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_time_now       (req_time_now),
      .req_ramp_index     (req_ramp_index),
      .req_ramp_value     (req_ramp_value),
      .req_position_value (req_position_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_step_pulse     (rsp_step_pulse),
      .rsp_move_done      (rsp_move_done),
      .rsp_position       (rsp_position),
      .rsp_index_fault    (rsp_index_fault),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Scheduler model
   // ------------------------------------------------------------------------

   // Returns {fault, interval}; an index outside the ramp reads as zero.
   function automatic logic [16:0] ramp_lookup(input logic [31:0] idx);
      if (idx >= {21'd0, cfg_accel} || idx >= RAMP_DEPTH) begin
         return {1'b1, 16'd0};
      end
      return {1'b0, ramp_mem[idx[9:0]]};
   endfunction

   // Applies one request to the model state and returns its result.
   function automatic step_result_type predict_schedule(input rtss_pkg::act_type act,
                                                        input logic [31:0] tnow,
                                                        input logic [9:0] ridx,
                                                        input logic [15:0] rval,
                                                        input logic [31:0] pval);
      step_result_type r;
      logic [31:0]     taken;
      logic [31:0]     total;
      logic [31:0]     accel;
      logic [16:0]     lk;
      logic            cruising;
      r        = '0;
      lk       = '0;
      cruising = 1'b0;
      taken    = {8'd0, sched_taken};
      total    = {8'd0, cfg_total};
      accel    = {21'd0, cfg_accel};
      case (act)
         rtss_pkg::ACT_LOAD: begin
            ramp_mem[ridx] = rval;
         end
         rtss_pkg::ACT_START: begin
            lk          = ramp_lookup(32'd0);
            sched_taken = 24'd1;
            sched_next  = tnow + {16'd0, lk[15:0]};
            r.fault     = lk[16];
            r.pulse     = 1'b1;
         end
         rtss_pkg::ACT_TICK: begin
            // Step only once the schedule is strictly behind the clock.
            if (taken < total && tnow > sched_next) begin
               if (taken < accel) begin
                  lk = ramp_lookup(taken);
               end else if (taken >= total - accel) begin
                  lk = ramp_lookup(total - taken - 32'd1);
               end else if (cfg_cruise == '0) begin
                  lk = ramp_lookup(accel - 32'd1);
               end else begin
                  cruising = 1'b1;
               end
               sched_next  = sched_next + (cruising ? {12'd0, cfg_cruise}
                                                    : {16'd0, lk[15:0]});
               r.fault     = lk[16];
               r.pulse     = 1'b1;
               sched_taken = sched_taken + 24'd1;
            end
         end
         rtss_pkg::ACT_SET_POS: begin
            sched_pos = pval;
         end
         default: begin
         end
      endcase
      if (r.pulse) begin
         sched_pos = cfg_dir ? sched_pos + 32'sd1 : sched_pos - 32'sd1;
      end
      r.done = ({8'd0, sched_taken} >= total);
      r.pos  = sched_pos;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Sends one request, waits for its transfer and records the prediction.
   task automatic issue_request(input rtss_pkg::act_type act, input logic [31:0] tnow,
                                input logic [9:0] ridx, input logic [15:0] rval,
                                input logic [31:0] pval);
      step_result_type r;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_time_now       <= tnow;
      req_ramp_index     <= ridx;
      req_ramp_value     <= rval;
      req_position_value <= pval;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_schedule(act, tnow, ridx, rval, pval);
      outcome_q.insert(outcome_q.size(), r);
      n_requests++;
      if (r.pulse) n_pulses++;
      if (r.fault) n_faults++;
      if (r.pulse && r.done && act == rtss_pkg::ACT_TICK) n_finished++;
   endtask

   function automatic logic [15:0] rand_interval();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'd50000;
         default: return 16'($urandom_range(0, 50000));
      endcase
   endfunction

   task automatic send_tick(input logic [31:0] tnow);
      issue_request(rtss_pkg::ACT_TICK, tnow, 10'($urandom_range(0, 1023)),
                    rand_interval(), $urandom);
   endtask

   task automatic send_start(input logic [31:0] tnow);
      issue_request(rtss_pkg::ACT_START, tnow, 10'($urandom_range(0, 1023)),
                    rand_interval(), $urandom);
   endtask

   task automatic send_load(input logic [9:0] idx, input logic [15:0] val);
      issue_request(rtss_pkg::ACT_LOAD, $urandom, idx, val, $urandom);
   endtask

   task automatic send_setpos(input logic [31:0] pos);
      issue_request(rtss_pkg::ACT_SET_POS, $urandom, 10'($urandom_range(0, 1023)),
                    rand_interval(), pos);
   endtask

   // Mostly times just past the schedule, with some that are due exactly,
   // some early and some at random.
   function automatic logic [31:0] pick_tick_time();
      case ($urandom_range(0, 19))
         0, 1:    return sched_next;
         2:       return sched_next - 32'($urandom_range(1, 100));
         3, 4:    return $urandom;
         default: return sched_next + 32'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [31:0] pick_start_time();
      if ($urandom_range(0, 7) == 0) return 32'hFFFF_FFFF - 32'($urandom_range(0, 100000));
      return $urandom;
   endfunction

   // Holds off new requests until every predicted result has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers once the block is idle.
   task automatic configure(input logic [23:0] total, input logic [10:0] accel,
                            input logic [19:0] cruise, input logic dir);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= rtss_pkg::REG_STEP_TOTAL;
      csr_wdata <= total;
      @(posedge clock);
      csr_index <= rtss_pkg::REG_ACCEL_STEPS;
      csr_wdata <= {13'd0, accel};
      @(posedge clock);
      csr_index <= rtss_pkg::REG_CRUISE;
      csr_wdata <= {4'd0, cruise};
      @(posedge clock);
      csr_index <= rtss_pkg::REG_DIRECTION;
      csr_wdata <= {23'd0, dir};
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_total  = total;
      cfg_accel  = accel;
      cfg_cruise = cruise;
      cfg_dir    = dir;
      n_settings++;
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   function automatic void log_mismatch(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   // Random back-pressure in bursts, with longer ready stretches between.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Each result transfer is compared against the oldest prediction.
   always @(posedge clock) begin : result_check
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            log_mismatch("result transfer with no request outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (rsp_step_pulse !== want.pulse || rsp_move_done !== want.done ||
                rsp_position !== want.pos || rsp_index_fault !== want.fault) begin
               log_mismatch($sformatf(
                  "expected pulse %0b done %0b pos %0d fault %0b, got %0b %0b %0d %0b",
                  want.pulse, want.done, $signed(want.pos), want.fault,
                  rsp_step_pulse, rsp_move_done, rsp_position, rsp_index_fault));
            end
         end
      end
   end

   // A long stretch without any transfer means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // With the reset settings a tick does nothing and a start still steps.
   task automatic test_reset_defaults();
      send_tick(32'hFFFF_FFFF);
      send_start(32'd0);
   endtask

   // Loads the leading ramp entries so that no later read hits an unwritten one.
   task automatic test_table_fill();
      int i;
      for (i = 0; i < RAMP_FILL; i++) begin
         if (i == 0 || i == RAMP_FILL - 1) begin
            send_load(10'(i), 16'd50000);
         end else if (i == 1) begin
            send_load(10'(i), 16'd0);
         end else begin
            send_load(10'(i), rand_interval());
         end
      end
   endtask

   // Full trapezoid without plateau: accelerate, repeat last entry, decelerate.
   task automatic test_trapezoid();
      configure(24'd8, 11'd3, 20'd0, 1'b1);
      send_start(32'd1000);
      send_tick(sched_next);
      repeat (7) send_tick(sched_next + 32'd1);
      send_tick(sched_next + 32'd100);
   endtask

   // Plateau steps use the cruise interval at its largest value.
   task automatic test_plateau();
      configure(24'd5, 11'd1, 20'hFFFFF, 1'b0);
      send_start(32'd0);
      repeat (4) send_tick(sched_next + 32'd1);
   endtask

   // No ramp entries in use: the start and every tick step flag a fault.
   task automatic test_missing_ramp();
      configure(24'd3, 11'd0, 20'd0, 1'b1);
      send_start(32'd5);
      repeat (2) send_tick(sched_next + 32'd1);
   endtask

   // Schedule wraps past the top of the time range.
   task automatic test_time_wrap();
      configure(24'd6, 11'd2, 20'd0, 1'b1);
      send_start(32'hFFFF_FFF0);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'd0);
      send_tick(sched_next + 32'd1);
   endtask

   // Position wraps both ways at the largest step total and ramp length.
   task automatic test_position_wrap();
      configure(24'hFFFFFF, 11'd1024, 20'd0, 1'b1);
      send_setpos(32'h7FFF_FFFF);
      send_start(32'd77);
      send_tick(sched_next + 32'd1);
      configure(24'hFFFFFF, 11'd1024, 20'hFFFFF, 1'b0);
      send_setpos(32'h8000_0000);
      send_start(32'd77);
   endtask

   // One move with random settings and a random mix of requests.
   task automatic run_random_move(input int count);
      logic [23:0] total;
      logic [10:0] accel;
      logic [19:0] cruise;
      int          i;
      case ($urandom_range(0, 9))
         0:       total = 24'd0;
         1:       total = 24'hFFFFFF;
         2:       total = 24'd1;
         default: total = 24'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 9))
         0:       accel = 11'd0;
         1:       accel = 11'd1024;
         2:       accel = 11'd1;
         default: accel = 11'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 4))
         0, 1:    cruise = 20'd0;
         2:       cruise = 20'hFFFFF;
         default: cruise = 20'($urandom_range(1, 3000));
      endcase
      configure(total, accel, cruise, 1'($urandom_range(0, 1)));
      send_start(pick_start_time());
      for (i = 1; i < count; i++) begin
         case ($urandom_range(0, 19))
            0, 1:    send_load(10'($urandom_range(0, 1023)), rand_interval());
            2:       send_setpos($urandom);
            3:       send_start(pick_start_time());
            default: send_tick(pick_tick_time());
         endcase
         // Now and then the sender waits for every result to drain.
         if ($urandom_range(0, 49) == 0) wait_for_results();
      end
      n_random += count;
   endtask

   task automatic test_random_moves();
      while (n_random < 500) run_random_move($urandom_range(15, 60));
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_steady_stream();
      idle_en = 1'b0;
      run_random_move(50);
      run_random_move(50);
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_action         <= rtss_pkg::ACT_LOAD;
      req_time_now       <= '0;
      req_ramp_index     <= '0;
      req_ramp_value     <= '0;
      req_position_value <= '0;
      csr_we             <= 1'b0;
      csr_index          <= rtss_pkg::REG_STEP_TOTAL;
      csr_wdata          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_table_fill();
      test_trapezoid();
      test_plateau();
      test_missing_ramp();
      test_time_wrap();
      test_position_wrap();
      test_random_moves();
      test_steady_stream();

      wait_for_results();
      repeat (6) @(posedge clock);
      if (outcome_q.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
      end

      $display("Covered %0d requests under %0d register settings.", n_requests, n_settings);
      $display("Saw %0d step pulses, %0d index faults and %0d finished moves; %0d errors.",
               n_pulses, n_faults, n_finished, n_errors);
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
